/* src/lcas_pkg.sv */
// shared constants and types for the life step core
`default_nettype none

package lcas_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;

    localparam int COL_W     = $clog2(MAX_COLUMNS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_CNT_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int SIZE_W      = 7;
    localparam int GEN_W       = 16;
    localparam int COORD_W     = 6;
    localparam int CMD_W       = 2;
    localparam int SUM_W       = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GENERATIONS = 2'd2;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic RES_READ = 1'b0;
    localparam logic RES_DONE = 1'b1;

    localparam logic [SUM_W-1:0] SUM_BIRTH = 4'd3;
    localparam logic [SUM_W-1:0] SUM_KEEP  = 4'd4;

    localparam logic [SIZE_W-1:0] RESET_COLUMNS     = 7'd64;
    localparam logic [SIZE_W-1:0] RESET_ROWS        = 7'd64;
    localparam logic [GEN_W-1:0]  RESET_GENERATIONS = 16'd1;

    typedef logic [MAX_COLUMNS-1:0] row_t;

    typedef struct packed {
        logic [COL_CNT_W-1:0] used_cols;
        logic                 row_inside;
    } rule_ctrl_t;

endpackage

`default_nettype wire

/* src/life_cellular_automaton_step_core.sv */
// top level of the toroidal life board with cell access and generation runs
//
// Input channel (in_valid / in_stall) carries one command per beat: write cell,
// run generations, or read cell. Output channel (out_valid / out_stall) returns
// one beat for a read (result_kind 0, read_alive) or at the end of a run
// (result_kind 1). Writes return nothing. Configuration is a plain write port
// (cfg_write, cfg_index, cfg_data) for columns, rows and generations per run.
// The board is held as rows of MAX_COLUMNS cells in two row-wide rams, one
// being the current board and the other receiving the next generation.
// A write reads the row, modifies it and writes it back; a read registers its
// output beat once the row is read. A generation walks all MAX_ROWS rows:
// each row costs three reads of the single read port of the source ram and a
// write into the other ram. A run repeats this for each generation owed, and
// stops early once a generation changes nothing; a zero count answers at once.
// After reset the block clears the first ram, one row per cycle, with in_stall
// high; configuration writes are taken meanwhile.
// One command is in work at a time. The output register holds a beat while
// out_stall is high; a new command is still taken, and its own result waits.
`default_nettype none

module life_cellular_automaton_step_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [lcas_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lcas_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [lcas_pkg::CMD_W-1:0]       command,
    input  wire logic [lcas_pkg::COORD_W-1:0]     cell_column,
    input  wire logic [lcas_pkg::COORD_W-1:0]     cell_row,
    input  wire logic                             cell_alive,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  result_kind,
    output logic                                  read_alive
);

    import lcas_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_CELL  = 8'b0000_0100,
        S_G_UP  = 8'b0000_1000,
        S_G_MID = 8'b0001_0000,
        S_G_DN  = 8'b0010_0000,
        S_G_WB  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] board_columns_reg;
    logic [SIZE_W-1:0] board_rows_reg;
    logic [GEN_W-1:0]  gen_count_reg;

    logic              buf_sel_reg, buf_sel_next;
    logic [ROW_W-1:0]  gen_row_reg, gen_row_next;
    logic [GEN_W-1:0]  gen_left_reg, gen_left_next;
    logic              changed_reg, changed_next;
    logic              out_valid_reg, out_valid_next;

    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              alive_reg, alive_next;
    logic              inside_reg, inside_next;
    row_t              up_reg, up_next;
    row_t              mid_reg, mid_next;
    logic              out_kind_reg, out_kind_next;
    logic              out_alive_reg, out_alive_next;

    logic [COL_CNT_W-1:0] used_cols;
    logic [ROW_CNT_W-1:0] used_rows;
    logic [ROW_CNT_W-1:0] rows_m1;
    logic [ROW_W-1:0]     last_row;
    logic [ROW_W-1:0]     up_row_addr;
    logic [ROW_W-1:0]     down_row_addr;
    logic                 cell_inside;
    logic                 in_accept;
    logic                 out_free;
    logic                 changed_gen;

    logic             src_re;
    logic [ROW_W-1:0] src_raddr;
    logic             wr_en;
    logic             wr_sel;
    logic [ROW_W-1:0] wr_addr;
    row_t             wr_data;
    row_t             src_rdata;
    row_t             cell_row_mod;
    row_t             new_row;
    rule_ctrl_t       rule_ctrl;

    logic             ram_we    [2];
    logic             ram_re    [2];
    row_t             ram_rdata [2];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_columns_reg <= RESET_COLUMNS;
            board_rows_reg    <= RESET_ROWS;
            gen_count_reg     <= RESET_GENERATIONS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_COLUMNS:     board_columns_reg <= cfg_data[SIZE_W-1:0];
                CFG_ROWS:        board_rows_reg    <= cfg_data[SIZE_W-1:0];
                CFG_GENERATIONS: gen_count_reg     <= cfg_data[GEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // board size in use
    always_comb
    begin
        priority if (board_columns_reg == '0)
            used_cols = COL_CNT_W'(1);
        else if (int'(board_columns_reg) > MAX_COLUMNS)
            used_cols = COL_CNT_W'(MAX_COLUMNS);
        else
            used_cols = COL_CNT_W'(board_columns_reg);

        priority if (board_rows_reg == '0)
            used_rows = ROW_CNT_W'(1);
        else if (int'(board_rows_reg) > MAX_ROWS)
            used_rows = ROW_CNT_W'(MAX_ROWS);
        else
            used_rows = ROW_CNT_W'(board_rows_reg);
    end

    assign rows_m1       = used_rows - ROW_CNT_W'(1);
    assign last_row      = rows_m1[ROW_W-1:0];
    assign up_row_addr   = (gen_row_reg == '0) ? last_row : gen_row_reg - ROW_W'(1);
    assign down_row_addr = (gen_row_reg == last_row) ? '0 : gen_row_reg + ROW_W'(1);
    assign cell_inside   = (int'(cell_column) < int'(used_cols)) &&
                           (int'(cell_row) < int'(used_rows));

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // board rams
    for (genvar p = 0; p < 2; p++)
    begin : gen_plane
        assign ram_we[p] = wr_en && (wr_sel == 1'(p));
        assign ram_re[p] = src_re && (buf_sel_reg == 1'(p));

        lcas_ram #(
            .WIDTH (MAX_COLUMNS),
            .DEPTH (MAX_ROWS)
        ) u_plane (
            .clk   (clk),
            .we    (ram_we[p]),
            .waddr (wr_addr),
            .wdata (wr_data),
            .re    (ram_re[p]),
            .raddr (src_raddr),
            .rdata (ram_rdata[p])
        );
    end

    assign src_rdata = ram_rdata[buf_sel_reg];

    always_comb
    begin
        cell_row_mod          = src_rdata;
        cell_row_mod[col_reg] = alive_reg;
    end

    assign rule_ctrl.used_cols  = used_cols;
    assign rule_ctrl.row_inside = (int'(gen_row_reg) < int'(used_rows));

    lcas_row_rule u_rule (
        .up_row   (up_reg),
        .mid_row  (mid_reg),
        .down_row (src_rdata),
        .ctrl     (rule_ctrl),
        .next_row (new_row)
    );

    assign changed_gen = changed_reg || (new_row != mid_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        buf_sel_next   = buf_sel_reg;
        gen_row_next   = gen_row_reg;
        gen_left_next  = gen_left_reg;
        changed_next   = changed_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd_next       = cmd_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        alive_next     = alive_reg;
        inside_next    = inside_reg;
        up_next        = up_reg;
        mid_next       = mid_reg;
        out_kind_next  = out_kind_reg;
        out_alive_next = out_alive_reg;
        src_re         = 1'b0;
        src_raddr      = gen_row_reg;
        wr_en          = 1'b0;
        wr_sel         = buf_sel_reg;
        wr_addr        = gen_row_reg;
        wr_data        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_sel  = 1'b0;
                wr_data = '0;
                if (gen_row_reg == ROW_W'(MAX_ROWS - 1))
                begin
                    gen_row_next = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    gen_row_next = gen_row_reg + ROW_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next    = command;
                    col_next    = COL_W'(cell_column);
                    row_next    = ROW_W'(cell_row);
                    alive_next  = cell_alive;
                    inside_next = cell_inside;
                    unique case (command)
                        CMD_WRITE, CMD_READ:
                        begin
                            src_re     = 1'b1;
                            src_raddr  = ROW_W'(cell_row);
                            state_next = S_CELL;
                        end
                        CMD_RUN:
                        begin
                            gen_left_next = gen_count_reg;
                            gen_row_next  = '0;
                            changed_next  = 1'b0;
                            state_next    = (gen_count_reg == '0) ? S_DONE : S_G_UP;
                        end
                        default: ;
                    endcase
                end
            end
            S_CELL:
            begin
                if (cmd_reg == CMD_WRITE)
                begin
                    wr_en      = inside_reg;
                    wr_sel     = buf_sel_reg;
                    wr_addr    = row_reg;
                    wr_data    = cell_row_mod;
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = RES_READ;
                    out_alive_next = inside_reg && src_rdata[col_reg];
                    state_next     = S_IDLE;
                end
            end
            S_G_UP:
            begin
                src_re     = 1'b1;
                src_raddr  = up_row_addr;
                state_next = S_G_MID;
            end
            S_G_MID:
            begin
                src_re     = 1'b1;
                src_raddr  = gen_row_reg;
                up_next    = src_rdata;
                state_next = S_G_DN;
            end
            S_G_DN:
            begin
                src_re     = 1'b1;
                src_raddr  = down_row_addr;
                mid_next   = src_rdata;
                state_next = S_G_WB;
            end
            S_G_WB:
            begin
                wr_en   = 1'b1;
                wr_sel  = ~buf_sel_reg;
                wr_addr = gen_row_reg;
                wr_data = new_row;
                if (gen_row_reg == ROW_W'(MAX_ROWS - 1))
                begin
                    buf_sel_next  = ~buf_sel_reg;
                    gen_left_next = gen_left_reg - GEN_W'(1);
                    gen_row_next  = '0;
                    changed_next  = 1'b0;
                    if ((gen_left_reg == GEN_W'(1)) || !changed_gen)
                        state_next = S_DONE;
                    else
                        state_next = S_G_UP;
                end
                else
                begin
                    gen_row_next = gen_row_reg + ROW_W'(1);
                    changed_next = changed_gen;
                    state_next   = S_G_UP;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = RES_DONE;
                    out_alive_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            buf_sel_reg   <= 1'b0;
            gen_row_reg   <= '0;
            gen_left_reg  <= '0;
            changed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_sel_reg   <= buf_sel_next;
            gen_row_reg   <= gen_row_next;
            gen_left_reg  <= gen_left_next;
            changed_reg   <= changed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        alive_reg     <= alive_next;
        inside_reg    <= inside_next;
        up_reg        <= up_next;
        mid_reg       <= mid_next;
        out_kind_reg  <= out_kind_next;
        out_alive_reg <= out_alive_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign read_alive  = out_alive_reg;

`ifndef SYNTHESIS
    // a generation writes only into the buffer that is not being read
    a_gen_write_other_plane: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_G_WB) |-> (ram_we[~buf_sel_reg] && !ram_we[buf_sel_reg]))
        else $error("generation write hit the source plane");

    // the last row of a generation swaps the buffers
    a_swap_after_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_G_WB && gen_row_reg == ROW_W'(MAX_ROWS - 1))
        |=> (buf_sel_reg != $past(buf_sel_reg)))
        else $error("buffers not swapped at end of generation");

    // a generation only runs with generations still owed
    a_gen_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_G_UP || state_reg == S_G_MID || state_reg == S_G_DN ||
         state_reg == S_G_WB) |-> (gen_left_reg != '0))
        else $error("generation running with none left");

    // run completion yields a done beat
    a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid && result_kind == RES_DONE))
        else $error("run finished without a done beat");

    // row counter parked at zero whenever the block is idle
    a_idle_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (gen_row_reg == '0))
        else $error("row counter not parked in idle");
`endif

endmodule

`default_nettype wire

/* src/lcas_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module lcas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/lcas_row_rule.sv */
// b3/s23 rule applied to one board row from its three source rows
`default_nettype none

module lcas_row_rule (
    input  wire lcas_pkg::row_t       up_row,
    input  wire lcas_pkg::row_t       mid_row,
    input  wire lcas_pkg::row_t       down_row,
    input  wire lcas_pkg::rule_ctrl_t ctrl,
    output lcas_pkg::row_t            next_row
);

    import lcas_pkg::*;

    function automatic row_t west_of(input row_t r, input logic [COL_W-1:0] last);
        row_t w;
        w = {r[MAX_COLUMNS-2:0], r[last]};
        return w;
    endfunction

    function automatic row_t east_of(input row_t r, input logic [COL_W-1:0] last);
        row_t e;
        e = {1'b0, r[MAX_COLUMNS-1:1]};
        for (int x = 0; x < MAX_COLUMNS; x++)
        begin
            if (COL_W'(x) == last)
            begin
                e[x] = r[0];
            end
        end
        return e;
    endfunction

    function automatic logic [SUM_W-1:0] count9(input logic [8:0] v);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int i = 0; i < 9; i++)
        begin
            s = s + SUM_W'(v[i]);
        end
        return s;
    endfunction

    logic [COL_CNT_W-1:0] cols_m1;
    logic [COL_W-1:0]     last_col;
    row_t                 uw, ue, mw, me, dw, de;

    assign cols_m1  = ctrl.used_cols - COL_CNT_W'(1);
    assign last_col = cols_m1[COL_W-1:0];

    always_comb
    begin
        logic [SUM_W-1:0] s;
        uw = west_of(up_row, last_col);
        ue = east_of(up_row, last_col);
        mw = west_of(mid_row, last_col);
        me = east_of(mid_row, last_col);
        dw = west_of(down_row, last_col);
        de = east_of(down_row, last_col);
        next_row = '0;
        for (int x = 0; x < MAX_COLUMNS; x++)
        begin
            s = count9({uw[x], up_row[x], ue[x], mw[x], mid_row[x], me[x],
                        dw[x], down_row[x], de[x]});
            if (ctrl.row_inside && (COL_CNT_W'(x) < ctrl.used_cols))
            begin
                if (mid_row[x])
                begin
                    next_row[x] = (s == SUM_BIRTH) || (s == SUM_KEEP);
                end
                else
                begin
                    next_row[x] = (s == SUM_BIRTH);
                end
            end
        end
    end

endmodule

`default_nettype wire
